/* rtl/bitmap_id_allocator_table_defines.svh */
// ---------------------------------------------------------------------------
// bitmap_id_allocator_table assertion macros
// concurrent assertion wrappers, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_TABLE_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_TABLE_DEFINES_SVH

`ifndef SYNTH
`define BIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BIA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BIA_ASSERT(lbl, prop, msg)
`define BIA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/bia_pkg.sv */
// ---------------------------------------------------------------------------
// bia_pkg
// shared widths, codes and defaults of the id allocator
// ---------------------------------------------------------------------------
package bia_pkg;

  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned WORD_BITS_DEF   = 64;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 3'd0,
    MODE_RELEASE = 3'd1,
    MODE_INSTALL = 3'd2,
    MODE_LOOKUP  = 3'd3,
    MODE_PICK    = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OCCUPIED = 2'd3
  } status_e;

endpackage

/* rtl/bia_if.sv */
// ---------------------------------------------------------------------------
// bia request and response channels
// valid/ready channels carrying the allocator payloads
// ---------------------------------------------------------------------------
interface bia_req_if #(
  parameter int unsigned HANDLE_BITS = bia_pkg::HANDLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [bia_pkg::MODE_W-1:0]   mode;
  logic [bia_pkg::ID_W-1:0]     id;
  logic [bia_pkg::ID_W-1:0]     start_id;
  logic [bia_pkg::LIMIT_W-1:0]  id_limit;
  logic [HANDLE_BITS-1:0]       handle;

  modport source (output valid, mode, id, start_id, id_limit, handle, input ready);
  modport sink   (input valid, mode, id, start_id, id_limit, handle, output ready);
endinterface

interface bia_rsp_if #(
  parameter int unsigned HANDLE_BITS = bia_pkg::HANDLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [bia_pkg::STATUS_W-1:0]  status;
  logic [bia_pkg::ID_W-1:0]      id_out;
  logic [HANDLE_BITS-1:0]        handle_out;

  modport source (output valid, status, id_out, handle_out, input ready);
  modport sink   (input valid, status, id_out, handle_out, output ready);
endinterface

/* rtl/bia_pri_enc.sv */
// ---------------------------------------------------------------------------
// bia_pri_enc
// lowest-set-bit priority encoder shared by the word and summary scans
// ---------------------------------------------------------------------------
module bia_pri_enc #(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0]         vec_i,
  output logic                     found_o,
  output logic [$clog2(WIDTH)-1:0] idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        found_o = 1'b1;
        idx_o   = ($clog2(WIDTH))'(i);
      end
    end
  end

endmodule

/* rtl/bia_handle_ram.sv */
// ---------------------------------------------------------------------------
// bia_handle_ram
// one write port, one registered read port handle storage
// ---------------------------------------------------------------------------
module bia_handle_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bitmap_id_allocator_table.sv */
// ---------------------------------------------------------------------------
// bitmap_id_allocator_table
// lowest-free id allocator over a used-bit map with a full-word summary,
// plus a handle table with install, lookup and pick
// ---------------------------------------------------------------------------
// sequence: release completes in dispatch; install, lookup and pick read the
//   handle table first; alloc visits bitmap words with the shared priority
//   encoder alternating between one used word and the summary map; any
//   request then waits while the previous response is still held
// throughput: one request at a time, the next accepted once the last is done
// reset: map and summary clear at once, the hint resets to 1; the handle
//   table is then swept to zero, during which no request is accepted
// ---------------------------------------------------------------------------
`include "bitmap_id_allocator_table_defines.svh"

module bitmap_id_allocator_table #(
  parameter int unsigned CAPACITY    = bia_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS   = bia_pkg::WORD_BITS_DEF,
  parameter int unsigned HANDLE_BITS = bia_pkg::HANDLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bia_req_if.sink   req_i,
  bia_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WI_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned OFF_W  = $clog2(WORD_BITS);
  // wide enough for ids, limits and the end of the last word
  localparam int unsigned CW     = (IDX_W + 2 > 11) ? IDX_W + 2 : 11;
  localparam int unsigned PE_W   = (WORD_BITS > NWORDS) ? WORD_BITS : NWORDS;
  localparam int unsigned PI_W   = $clog2(PE_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN_WORD,
    S_SCAN_SKIP,
    S_COMMIT,
    S_HANDLE,
    S_FIN
  } state_e;

  state_e state_q;

  // latched request
  logic [bia_pkg::MODE_W-1:0]  mode_q;
  logic [bia_pkg::ID_W-1:0]    id_q;
  logic [bia_pkg::ID_W-1:0]    start_q;
  logic [bia_pkg::LIMIT_W-1:0] limit_q;
  logic [HANDLE_BITS-1:0]      handle_q;

  // allocator state
  logic [WORD_BITS-1:0] used_q [NWORDS];
  logic [NWORDS-1:0]    full_q;
  logic [CW-1:0]        hint_q;

  // scan position
  logic [WI_W-1:0]  cur_w_q;
  logic [OFF_W-1:0] cur_off_q;

  // working result
  logic [bia_pkg::STATUS_W-1:0] st_q;
  logic [bia_pkg::ID_W-1:0]     ido_q;
  logic [HANDLE_BITS-1:0]       ho_q;

  // response register
  logic                         out_vld_q;
  logic [bia_pkg::STATUS_W-1:0] out_st_q;
  logic [bia_pkg::ID_W-1:0]     out_id_q;
  logic [HANDLE_BITS-1:0]       out_h_q;

  logic [IDX_W-1:0] clr_cnt_q;

  // widened views of the request
  logic [CW-1:0]    id_c, start_c, limit_c, n_c, f_c;
  logic [IDX_W-1:0] id_idx;
  logic [WI_W-1:0]  id_w;
  logic [OFF_W-1:0] id_off;
  logic             id_ok, mode_bad;

  assign id_c    = CW'(id_q);
  assign start_c = CW'(start_q);
  assign limit_c = CW'(limit_q);
  assign id_idx  = id_c[IDX_W-1:0];
  assign id_w    = WI_W'(id_c / WORD_BITS);
  assign id_off  = OFF_W'(id_c % WORD_BITS);
  assign id_ok   = id_c < CW'(CAPACITY);
  assign mode_bad = mode_q > bia_pkg::MODE_PICK;
  // alloc search start: max(start, hint)
  assign n_c     = (start_c < hint_q) ? hint_q : start_c;
  // id found by the scan, from word and bit position
  assign f_c     = CW'(cur_w_q) * CW'(WORD_BITS) + CW'(cur_off_q);

  // shared priority encoder: free bits of one word, or non-full words above
  logic [PE_W-1:0] pe_vec;
  logic            pe_found;
  logic [PI_W-1:0] pe_idx;

  always_comb begin
    pe_vec = '0;
    if (state_q == S_SCAN_SKIP) begin
      for (int i = 0; i < PE_W; i++) begin
        pe_vec[i] = (i < NWORDS) && (i > int'(cur_w_q)) && !full_q[i % NWORDS];
      end
    end else begin
      pe_vec = PE_W'(~used_q[cur_w_q] & ({WORD_BITS{1'b1}} << cur_off_q));
    end
  end

  bia_pri_enc #(.WIDTH(PE_W)) u_pri_enc (
    .vec_i   (pe_vec),
    .found_o (pe_found),
    .idx_o   (pe_idx)
  );

  // handle table
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [HANDLE_BITS-1:0] ram_wdata, ram_rdata;
  logic                   rd_zero;

  assign rd_zero = (ram_rdata == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = id_idx;
    ram_wdata = '0;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
    end else if (state_q == S_HANDLE && rd_zero && mode_q == bia_pkg::MODE_INSTALL) begin
      ram_we    = 1'b1;
      ram_wdata = handle_q;
    end else if (state_q == S_HANDLE && !rd_zero && mode_q == bia_pkg::MODE_PICK) begin
      ram_we    = 1'b1;
    end
  end

  bia_handle_ram #(.DEPTH(CAPACITY), .DATA_W(HANDLE_BITS)) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (id_idx),
    .rdata_o (ram_rdata)
  );

  // commit check and full-word detection for the found id
  logic                 commit_ok;
  logic [WORD_BITS-1:0] word_set;

  assign commit_ok = (f_c < limit_c) && (f_c < CW'(CAPACITY));
  assign word_set  = used_q[cur_w_q] | ({{(WORD_BITS-1){1'b0}}, 1'b1} << cur_off_q);

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      hint_q    <= CW'(1);
      full_q    <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NWORDS; i++) begin
        used_q[i] <= '0;
      end
    end else begin
      // response taken; S_FIN loads the register itself
      if (rsp_o.ready && state_q != S_FIN) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          // sweep the handle table to empty
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == IDX_W'(CAPACITY - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            mode_q   <= req_i.mode;
            id_q     <= req_i.id;
            start_q  <= req_i.start_id;
            limit_q  <= req_i.id_limit;
            handle_q <= req_i.handle;
            state_q  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          ido_q <= id_q;
          ho_q  <= '0;
          if (mode_q == bia_pkg::MODE_ALLOC) begin
            if (n_c >= CW'(CAPACITY)) begin
              st_q    <= bia_pkg::ST_NOFREE;
              state_q <= S_FIN;
            end else begin
              st_q      <= bia_pkg::ST_OK;
              cur_w_q   <= WI_W'(n_c / WORD_BITS);
              cur_off_q <= OFF_W'(n_c % WORD_BITS);
              state_q   <= S_SCAN_WORD;
            end
          end else if (mode_bad || !id_ok) begin
            st_q    <= bia_pkg::ST_INVALID;
            state_q <= S_FIN;
          end else if (mode_q == bia_pkg::MODE_RELEASE) begin
            st_q                 <= bia_pkg::ST_OK;
            used_q[id_w][id_off] <= 1'b0;
            full_q[id_w]         <= 1'b0;
            if (id_c < hint_q) begin
              hint_q <= id_c;
            end
            state_q <= S_FIN;
          end else begin
            // table read issued, data lands next cycle
            st_q    <= bia_pkg::ST_OK;
            state_q <= S_HANDLE;
          end
        end
        S_SCAN_WORD: begin
          if (pe_found) begin
            cur_off_q <= pe_idx[OFF_W-1:0];
            state_q   <= S_COMMIT;
          end else begin
            state_q <= S_SCAN_SKIP;
          end
        end
        S_SCAN_SKIP: begin
          // jump to the next word not marked full
          if (pe_found) begin
            cur_w_q   <= pe_idx[WI_W-1:0];
            cur_off_q <= '0;
            state_q   <= S_SCAN_WORD;
          end else begin
            st_q    <= bia_pkg::ST_NOFREE;
            state_q <= S_FIN;
          end
        end
        S_COMMIT: begin
          if (commit_ok) begin
            used_q[cur_w_q] <= word_set;
            if (&word_set) begin
              full_q[cur_w_q] <= 1'b1;
            end
            if (start_c <= hint_q) begin
              hint_q <= f_c + CW'(1);
            end
            ido_q <= f_c[bia_pkg::ID_W-1:0];
          end else begin
            st_q <= bia_pkg::ST_NOFREE;
          end
          state_q <= S_FIN;
        end
        S_HANDLE: begin
          priority if (mode_q == bia_pkg::MODE_INSTALL) begin
            if (!rd_zero) begin
              st_q <= bia_pkg::ST_OCCUPIED;
            end
          end else if (mode_q == bia_pkg::MODE_LOOKUP) begin
            ho_q <= ram_rdata;
          end else begin
            // pick: take a nonzero handle out and free the id
            if (rd_zero) begin
              st_q <= bia_pkg::ST_INVALID;
            end else begin
              ho_q                 <= ram_rdata;
              used_q[id_w][id_off] <= 1'b0;
              full_q[id_w]         <= 1'b0;
              if (id_c < hint_q) begin
                hint_q <= id_c;
              end
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          // hand over once the response register is free
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q <= 1'b1;
            out_st_q  <= st_q;
            out_id_q  <= ido_q;
            out_h_q   <= ho_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.id_out     = out_id_q;
  assign rsp_o.handle_out = out_h_q;

  `BIA_ASSERT(a_hint_bound, (hint_q <= CW'(CAPACITY)), "hint beyond capacity")
  `BIA_ASSERT(a_scan_not_full, ((state_q == S_SCAN_WORD && pe_found) |-> !full_q[cur_w_q]), "free bit found in word marked full")
  `BIA_ASSERT(a_commit_sets, ((state_q == S_COMMIT && commit_ok) |=> used_q[$past(cur_w_q)][$past(cur_off_q)]), "granted id not marked used")
  `BIA_ASSERT_ALWAYS(a_no_req_clear, (!(state_q == S_CLEAR && req_i.ready)), "request taken during table clear")

endmodule

/* tb/bia_tb_pkg.sv */
// ---------------------------------------------------------------------------
// bia_tb_pkg
// predictor and result store for the id allocator testbench
// ---------------------------------------------------------------------------
package bia_tb_pkg;
  import bia_pkg::*;

  localparam int unsigned NUM_IDS  = CAPACITY_DEF;
  localparam int unsigned WBITS    = WORD_BITS_DEF;
  localparam int unsigned NUM_WRDS = NUM_IDS / WBITS;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     id;
    logic [ID_W-1:0]     start_id;
    logic [LIMIT_W-1:0]  id_limit;
    logic [31:0]         handle;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_out;
    logic [31:0]         handle_out;
  } alloc_rsp_t;

  class alloc_scoreboard;
    logic [WBITS-1:0]    used_map [NUM_WRDS];
    logic [NUM_WRDS-1:0] full_map;
    logic [31:0]         handles  [NUM_IDS];
    int unsigned         hint;
    alloc_rsp_t          pending_q [$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         grants;
    int unsigned         nofree_cnt;

    function new();
      foreach (used_map[i]) used_map[i] = '0;
      foreach (handles[i]) handles[i] = '0;
      full_map   = '0;
      hint       = 1;
      mismatches = 0;
      checked    = 0;
      grants     = 0;
      nofree_cnt = 0;
    endfunction

    function bit is_used(int unsigned n);
      return used_map[n / WBITS][n % WBITS];
    endfunction

    // lowest free id at or above from, skipping words marked full
    function int unsigned lowest_free(int unsigned from);
      int unsigned w;
      w = from / WBITS;
      while (w < NUM_WRDS && full_map[w]) w++;
      if (w >= NUM_WRDS) return NUM_IDS;
      if (w * WBITS > from) from = w * WBITS;
      for (int unsigned n = from; n < NUM_IDS; n++)
        if (!is_used(n)) return n;
      return NUM_IDS;
    endfunction

    function void free_id(int unsigned n);
      used_map[n / WBITS][n % WBITS] = 1'b0;
      full_map[n / WBITS] = 1'b0;
      if (n < hint) hint = n;
    endfunction

    function void note_request(alloc_req_t r);
      alloc_rsp_t  e;
      int unsigned n;
      e.status     = ST_OK;
      e.id_out     = r.id;
      e.handle_out = '0;
      if (r.mode == MODE_ALLOC) begin
        n = (r.start_id < hint) ? hint : r.start_id;
        if (n < NUM_IDS) n = lowest_free(n);
        if (n >= r.id_limit || n >= NUM_IDS) begin
          e.status = ST_NOFREE;
          nofree_cnt++;
        end else begin
          if (r.start_id <= hint) hint = n + 1;
          used_map[n / WBITS][n % WBITS] = 1'b1;
          if (&used_map[n / WBITS]) full_map[n / WBITS] = 1'b1;
          e.id_out = n[ID_W-1:0];
          grants++;
        end
      end else if (r.mode > MODE_PICK) begin
        e.status = ST_INVALID;
      end else if (r.mode == MODE_RELEASE) begin
        free_id(r.id);
      end else if (r.mode == MODE_INSTALL) begin
        if (handles[r.id] != 0) e.status = ST_OCCUPIED;
        else handles[r.id] = r.handle;
      end else if (r.mode == MODE_LOOKUP) begin
        e.handle_out = handles[r.id];
      end else begin
        if (handles[r.id] == 0) begin
          e.status = ST_INVALID;
        end else begin
          e.handle_out = handles[r.id];
          handles[r.id] = '0;
          free_id(r.id);
        end
      end
      pending_q.push_back(e);
    endfunction

    function void check_response(alloc_rsp_t a);
      alloc_rsp_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response status=%0d id=%0d handle=%h",
                   a.status, a.id_out, a.handle_out);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.status !== e.status || a.id_out !== e.id_out ||
          a.handle_out !== e.handle_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp status=%0d id=%0d handle=%h, got status=%0d id=%0d handle=%h",
                   checked, e.status, e.id_out, e.handle_out,
                   a.status, a.id_out, a.handle_out);
      end
    endfunction
  endclass
endpackage

/* tb/bitmap_id_allocator_table_tb.sv */
// ---------------------------------------------------------------------------
// bitmap_id_allocator_table_tb
// drives alloc, release, install, lookup and pick requests with random gaps
// and response stalls; every response is checked against a local predictor
// ---------------------------------------------------------------------------
module bitmap_id_allocator_table_tb;
  import bia_pkg::*;
  import bia_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;

  bia_req_if req_if ();
  bia_rsp_if rsp_if ();

  bitmap_id_allocator_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  alloc_scoreboard sb;
  int unsigned     sent;
  int unsigned     idle_cycles;
  bit              stall_free;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one request per call, entered at a falling edge; the gap after the
  // accepted request is drawn here, valid stays up when the gap is zero
  task automatic send_request(alloc_req_t r);
    int unsigned gap;
    req_if.valid    <= 1'b1;
    req_if.mode     <= r.mode;
    req_if.id       <= r.id;
    req_if.start_id <= r.start_id;
    req_if.id_limit <= r.id_limit;
    req_if.handle   <= r.handle;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    sent++;
    gap = stall_free ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // drop valid and wait until every expected response has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic alloc_req_t mk(logic [MODE_W-1:0] m, int unsigned i,
                                    int unsigned s, int unsigned l,
                                    logic [31:0] h);
    alloc_req_t r;
    r.mode = m; r.id = ID_W'(i); r.start_id = ID_W'(s); r.id_limit = LIMIT_W'(l);
    r.handle = h;
    return r;
  endfunction

  // mostly meaningful requests: alloc, release, install, lookup and pick on ids within span
  function automatic alloc_req_t rand_request(int unsigned span);
    alloc_req_t r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    r.handle = $urandom();
    r.id = ID_W'($urandom_range(0, span));
    r.start_id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 1023))
                                             : ID_W'($urandom_range(0, span));
    case ($urandom_range(0, 5))
      0:       r.id_limit = LIMIT_W'($urandom_range(0, 2047));
      1:       r.id_limit = LIMIT_W'(1024);
      default: r.id_limit = LIMIT_W'($urandom_range(span, 1024));
    endcase
    if (sel < 35)      r.mode = MODE_ALLOC;
    else if (sel < 50) r.mode = MODE_RELEASE;
    else if (sel < 68) r.mode = MODE_INSTALL;
    else if (sel < 80) r.mode = MODE_LOOKUP;
    else if (sel < 97) r.mode = MODE_PICK;
    else               r.mode = MODE_W'($urandom_range(5, 7));
    return r;
  endfunction

  // response side: random ready stalls, sample at the rising edge
  initial begin
    int unsigned stall;
    alloc_rsp_t  a;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      a.status     = rsp_if.status;
      a.id_out     = rsp_if.id_out;
      a.handle_out = rsp_if.handle_out;
      sb.check_response(a);
      stall = stall_free ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned span;
    sb         = new();
    sent       = 0;
    stall_free = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_ALLOC;
    req_if.id       = '0;
    req_if.start_id = '0;
    req_if.id_limit = '0;
    req_if.handle   = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: fresh hint, limits, every mode, out-of-range and edge values
    send_request(mk(MODE_ALLOC,   0,    0,    1024, 32'h0));
    send_request(mk(MODE_ALLOC,   0,    0,    0,    32'h0));
    send_request(mk(MODE_ALLOC,   0,    1023, 2047, 32'h0));
    send_request(mk(MODE_ALLOC,   0,    1023, 1024, 32'h0));
    send_request(mk(MODE_ALLOC,   0,    5,    1024, 32'h0));
    send_request(mk(MODE_INSTALL, 1,    0,    0,    32'hFFFF_FFFF));
    send_request(mk(MODE_INSTALL, 1,    0,    0,    32'h1234_5678));
    send_request(mk(MODE_LOOKUP,  1,    0,    0,    32'h0));
    send_request(mk(MODE_INSTALL, 0,    0,    0,    32'h0));
    send_request(mk(MODE_PICK,    0,    0,    0,    32'h0));
    send_request(mk(MODE_PICK,    1,    0,    0,    32'h0));
    send_request(mk(MODE_LOOKUP,  1,    0,    0,    32'h0));
    send_request(mk(MODE_RELEASE, 1023, 0,    0,    32'h0));
    send_request(mk(MODE_RELEASE, 0,    0,    0,    32'h0));
    send_request(mk(MODE_INSTALL, 1023, 0,    0,    32'h8000_0001));
    send_request(mk(MODE_LOOKUP,  1023, 0,    0,    32'h0));
    send_request(mk(3'd5,         7,    0,    0,    32'h0));
    send_request(mk(3'd7,         1023, 1023, 2047, 32'hFFFF_FFFF));
    // fill a whole word so the summary bit sets, then release into it
    for (int i = 0; i < 70; i++)
      send_request(mk(MODE_ALLOC, 0, 0, 1024, 32'h0));
    send_request(mk(MODE_RELEASE, 40, 0, 0, 32'h0));
    send_request(mk(MODE_ALLOC,   0,  0, 1024, 32'h0));

    // wait for the pipe to drain once, with no idling
    stall_free = 1'b1;
    drain();
    stall_free = 1'b0;

    // random: small id spans keep hits likely, some phases use the whole map
    for (int i = 0; i < 1600; i++) begin
      span = (i % 400 < 300) ? 127 : 1023;
      if (i % 500 == 250) begin
        drain();
      end
      if (i >= 1300 && i < 1400) stall_free = 1'b1;
      else stall_free = 1'b0;
      send_request(rand_request(span));
    end
    // alloc from random starts near the top of the map at the end
    for (int i = 0; i < 40; i++)
      send_request(mk(MODE_ALLOC, 0, $urandom_range(900, 1023), 1024, 32'h0));

    drain();
    repeat (50) @(negedge clk_i);

    $display("sent %0d requests, checked %0d responses: %0d grants, %0d alloc failures",
             sent, sb.checked, sb.grants, sb.nofree_cnt);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/bia_pkg.sv
rtl/bia_if.sv
rtl/bia_pri_enc.sv
rtl/bia_handle_ram.sv
rtl/bitmap_id_allocator_table.sv
tb/bia_tb_pkg.sv
tb/bitmap_id_allocator_table_tb.sv
